FILE: rtl/core/pidtc_pkg.sv
// Shared types and constants of the PID temperature controller.
// No dependencies; every other file of the block but pidtc_smul refers to it by scoped names.
`default_nettype none

package pidtc_pkg;

  localparam int GAIN_W    = 24;
  localparam int TEMP_W    = 17;
  localparam int ERR_W     = 18;
  localparam int IDX_W     = 2;
  // Gain products: signed err (ERR_W) times unsigned gain (GAIN_W), one guard bit.
  localparam int PROD_W    = ERR_W + GAIN_W + 1;
  // Q.16 term after dropping 8 fraction bits of the Q.24 product.
  localparam int TERM_W    = ERR_W + GAIN_W - 8;
  localparam int INTEG_W   = 32;
  localparam int FRAC_W    = 16;

  // Sensor scale 2^16 * 256 / 2.03636, fits in 24 bits as a positive number.
  localparam logic [GAIN_W-1:0] SENSOR_K   = 24'd8238826;
  localparam logic [TEMP_W-1:0] TEMP_MAX   = 17'h1FFFF;
  localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;

  localparam logic [GAIN_W-1:0] KP_RESET = 24'd655360;
  localparam logic [GAIN_W-1:0] KI_RESET = 24'd13107;
  localparam logic [GAIN_W-1:0] KD_RESET = 24'd328;

  typedef enum logic [IDX_W-1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCALE = 8'b0000_0010,
    S_TEMP  = 8'b0000_0100,
    S_ERR   = 8'b0000_1000,
    S_GAIN  = 8'b0001_0000,
    S_ACCUM = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_WRITE = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/pidtc_ifs.sv
// Valid/ready channels of the PID temperature controller: sample in, result out.
// Depends on pidtc_pkg for the fixed field widths.
`default_nettype none

interface pidtc_in_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] reference_code;
  logic [ADC_BITS-1:0] sensor_code;

  modport source (output valid, output reference_code, output sensor_code, input ready);
  modport sink   (input valid, input reference_code, input sensor_code, output ready);
endinterface

interface pidtc_out_if #(
  parameter int DUTY_BITS = 10
);
  logic                                valid;
  logic                                ready;
  logic        [DUTY_BITS-1:0]         heater_duty;
  logic signed [pidtc_pkg::ERR_W-1:0]  control_error;
  logic        [pidtc_pkg::TEMP_W-1:0] reference_temp;
  logic        [pidtc_pkg::TEMP_W-1:0] sensor_temp;

  modport source (output valid, output heater_duty, output control_error,
                  output reference_temp, output sensor_temp, input ready);
  modport sink   (input valid, input heater_duty, input control_error,
                  input reference_temp, input sensor_temp, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pidtc_regs.sv
// Gain register file of the PID temperature controller.
// Depends on pidtc_pkg for the index codes, reset values and gains_t.
`default_nettype none

module pidtc_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pidtc_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [pidtc_pkg::GAIN_W-1:0]   cfg_data,
  output pidtc_pkg::gains_t                   gains
);

  pidtc_pkg::gains_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.kp <= pidtc_pkg::KP_RESET;
      regs.ki <= pidtc_pkg::KI_RESET;
      regs.kd <= pidtc_pkg::KD_RESET;
    end else if (cfg_we) begin
      unique case (pidtc_pkg::reg_idx_t'(cfg_index))
        pidtc_pkg::REG_KP: regs.kp <= cfg_data;
        pidtc_pkg::REG_KI: regs.ki <= cfg_data;
        pidtc_pkg::REG_KD: regs.kd <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign gains = regs;

endmodule

`default_nettype wire

FILE: rtl/core/pidtc_smul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle. No package dependencies.
`default_nettype none

module pidtc_smul #(
  parameter int A_W = 18,
  parameter int B_W = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [A_W-1:0]  a,
  input  wire logic        [B_W-1:0]  b,
  output logic                        busy,
  output logic signed [A_W+B_W:0]     product
);

  localparam int CW = $clog2(B_W + 1);

  logic signed [A_W:0]   hi;
  logic        [B_W-1:0] lo;
  logic signed [A_W-1:0] mcand;
  logic        [CW-1:0]  cnt;
  logic signed [A_W:0]   psum;

  // Partial sum stays within A_W+1 signed bits for an unsigned multiplier.
  always_comb begin
    psum = lo[0] ? hi + {mcand[A_W-1], mcand} : hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(B_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= b;
      mcand <= a;
    end else if (busy) begin
      // shift the product right one place, multiplier bits fall out of lo
      hi <= {psum[A_W], psum[A_W:1]};
      lo <= {psum[0], lo[B_W-1:1]};
    end
  end

  assign product = {hi, lo};

endmodule

`default_nettype wire

FILE: rtl/core/pid_temperature_controller_top.sv
// Top level of the PID temperature controller (derivative on measurement).
// Depends on pidtc_pkg, pidtc_ifs, pidtc_regs and pidtc_smul.
//
//   channel  dir  handshake     word
//   sample   in   valid/ready   reference_code, sensor_code
//   result   out  valid/ready   heater_duty, control_error, reference_temp, sensor_temp
//   cfg      in   cfg_we        cfg_index, cfg_data (gain registers kp, ki, kd)
//
// One word passes from accept to result through the serial sensor-scaling
// multiplier, the temperature and error steps, the three serial gain multipliers
// running side by side, and the accumulate, sum and write steps.
// A new sample is taken once the previous one has left the sequencer, even while
// its result still waits in the output register. Synchronous reset clears the
// gains to their defaults, the integral and previous sensor value to zero.
`default_nettype none

module pid_temperature_controller_top #(
  parameter int ADC_BITS  = 10,
  parameter int DUTY_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pidtc_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [pidtc_pkg::GAIN_W-1:0]  cfg_data,
  pidtc_in_if.sink                           sample,
  pidtc_out_if.source                        result
);

  localparam int TEMP_W  = pidtc_pkg::TEMP_W;
  localparam int ERR_W   = pidtc_pkg::ERR_W;
  localparam int GAIN_W  = pidtc_pkg::GAIN_W;
  localparam int TERM_W  = pidtc_pkg::TERM_W;
  localparam int INTEG_W = pidtc_pkg::INTEG_W;
  localparam int FRAC_W  = pidtc_pkg::FRAC_W;
  // raw temperature width before saturation, not narrower than TEMP_W for ADC_BITS >= 8
  localparam int TW      = ADC_BITS + 9;
  localparam int SP_W    = GAIN_W + ADC_BITS + 1;
  localparam int PD_W    = TERM_W + 1;
  localparam int SUM_W   = TERM_W + 2;
  localparam int Q_W     = SUM_W - 1 - FRAC_W;

  pidtc_pkg::state_t state, state_next;
  pidtc_pkg::gains_t gains;

  logic [ADC_BITS-1:0]       rc_q;
  logic [ADC_BITS-1:0]       sc_q;
  logic [TEMP_W-1:0]         ref_temp;
  logic [TEMP_W-1:0]         sens_temp;
  logic [TEMP_W-1:0]         prev_sens;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [INTEG_W-1:0] integ;
  logic signed [PD_W-1:0]    pd;
  logic [DUTY_BITS-1:0]      duty_q;

  logic                      sample_fire;
  logic                      sens_busy;
  logic signed [SP_W-1:0]    sens_prod;
  logic                      gain_start;
  logic                      kp_busy, ki_busy, kd_busy;
  logic signed [pidtc_pkg::PROD_W-1:0] kp_prod, ki_prod, kd_prod;
  logic signed [TERM_W-1:0]  prop, iterm, deriv;

  logic [TW-1:0]             ref_raw;
  logic [SP_W-1:0]           sens_rnd;
  logic [TW-1:0]             sens_raw;
  logic signed [ERR_W-1:0]   err_c;
  logic signed [ERR_W-1:0]   dsens_c;
  logic signed [INTEG_W+2:0] isum;
  logic signed [SUM_W-1:0]   total;
  logic [Q_W-1:0]            q;
  logic [DUTY_BITS-1:0]      duty_c;
  logic                      result_load;

  pidtc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  assign sample_fire  = sample.valid && sample.ready;
  assign sample.ready = (state == pidtc_pkg::S_IDLE);
  assign gain_start   = (state == pidtc_pkg::S_ERR);

  // sensor code times SENSOR_K, one code bit a cycle
  pidtc_smul #(.A_W(GAIN_W), .B_W(ADC_BITS)) u_sens_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (sample_fire),
    .a       (pidtc_pkg::SENSOR_K),
    .b       (sample.sensor_code),
    .busy    (sens_busy),
    .product (sens_prod)
  );

  pidtc_smul #(.A_W(ERR_W), .B_W(GAIN_W)) u_kp_mul (
    .clk (clk), .rst (rst), .start (gain_start),
    .a (err_c), .b (gains.kp), .busy (kp_busy), .product (kp_prod)
  );

  pidtc_smul #(.A_W(ERR_W), .B_W(GAIN_W)) u_ki_mul (
    .clk (clk), .rst (rst), .start (gain_start),
    .a (err_c), .b (gains.ki), .busy (ki_busy), .product (ki_prod)
  );

  pidtc_smul #(.A_W(ERR_W), .B_W(GAIN_W)) u_kd_mul (
    .clk (clk), .rst (rst), .start (gain_start),
    .a (dsens_c), .b (gains.kd), .busy (kd_busy), .product (kd_prod)
  );

  // Q.24 -> Q.16: dropping the low bits of a two's complement word floors
  assign prop  = kp_prod[TERM_W+7:8];
  assign iterm = ki_prod[TERM_W+7:8];
  assign deriv = kd_prod[TERM_W+7:8];

  always_comb begin
    ref_raw  = (TW'(rc_q) << 4) + (TW'(rc_q) << 3) + TW'(rc_q);
    sens_rnd = SP_W'(sens_prod) + SP_W'(pidtc_pkg::ROUND_HALF);
    sens_raw = sens_rnd[SP_W-1:FRAC_W];
    err_c    = $signed({1'b0, ref_temp}) - $signed({1'b0, sens_temp});
    dsens_c  = $signed({1'b0, prev_sens}) - $signed({1'b0, sens_temp});
    isum     = {{3{integ[INTEG_W-1]}}, integ} + (INTEG_W+3)'(iterm);
    total    = {pd[PD_W-1], pd} + SUM_W'(integ);
    q        = total[SUM_W-2:FRAC_W];
    priority if (total[SUM_W-1] || q == '0) begin
      duty_c = '0;
    end else if (q[Q_W-1:DUTY_BITS] != '0) begin
      duty_c = '1;
    end else begin
      duty_c = q[DUTY_BITS-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pidtc_pkg::S_IDLE:  if (sample.valid) state_next = pidtc_pkg::S_SCALE;
      pidtc_pkg::S_SCALE: if (!sens_busy) state_next = pidtc_pkg::S_TEMP;
      pidtc_pkg::S_TEMP:  state_next = pidtc_pkg::S_ERR;
      pidtc_pkg::S_ERR:   state_next = pidtc_pkg::S_GAIN;
      pidtc_pkg::S_GAIN:  if (!kp_busy) state_next = pidtc_pkg::S_ACCUM;
      pidtc_pkg::S_ACCUM: state_next = pidtc_pkg::S_SUM;
      pidtc_pkg::S_SUM:   state_next = pidtc_pkg::S_WRITE;
      pidtc_pkg::S_WRITE: if (result_load) state_next = pidtc_pkg::S_IDLE;
      default:            state_next = pidtc_pkg::S_IDLE;
    endcase
  end

  assign result_load = (state == pidtc_pkg::S_WRITE) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pidtc_pkg::S_IDLE;
      integ        <= '0;
      prev_sens    <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pidtc_pkg::S_ERR) begin
        prev_sens <= sens_temp;
      end
      if (state == pidtc_pkg::S_ACCUM) begin
        // saturate at the 32-bit limits
        if (isum[INTEG_W+2:INTEG_W-1] != '0 && isum[INTEG_W+2:INTEG_W-1] != '1) begin
          integ <= isum[INTEG_W+2] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                   : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
          integ <= isum[INTEG_W-1:0];
        end
      end
      if (result_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      rc_q <= sample.reference_code;
      sc_q <= sample.sensor_code;
    end
    if (state == pidtc_pkg::S_TEMP) begin
      ref_temp  <= (ref_raw  > TW'(pidtc_pkg::TEMP_MAX)) ? pidtc_pkg::TEMP_MAX
                                                         : ref_raw[TEMP_W-1:0];
      sens_temp <= (sens_raw > TW'(pidtc_pkg::TEMP_MAX)) ? pidtc_pkg::TEMP_MAX
                                                         : sens_raw[TEMP_W-1:0];
    end
    if (state == pidtc_pkg::S_ERR) begin
      err_q <= err_c;
    end
    if (state == pidtc_pkg::S_ACCUM) begin
      pd <= PD_W'(prop) + PD_W'(deriv);
    end
    if (state == pidtc_pkg::S_SUM) begin
      duty_q <= duty_c;
    end
    if (result_load) begin
      result.heater_duty    <= duty_q;
      result.control_error  <= err_q;
      result.reference_temp <= ref_temp;
      result.sensor_temp    <= sens_temp;
    end
  end

  // sc_q is kept for the multiplier start check below
  a_sens_start: assert property (@(posedge clk) disable iff (rst)
    sample_fire |=> sens_busy && state == pidtc_pkg::S_SCALE && sc_q == $past(sample.sensor_code))
    else $error("sensor multiply did not start on accept");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    (kp_busy || ki_busy || kd_busy) |-> state == pidtc_pkg::S_GAIN && kp_busy && ki_busy && kd_busy)
    else $error("gain multipliers out of step with sequencer");

  a_integ_hold: assert property (@(posedge clk) disable iff (rst)
    state != pidtc_pkg::S_ACCUM |=> $stable(integ))
    else $error("integral changed outside accumulate step");

  a_result_wait: assert property (@(posedge clk) disable iff (rst)
    state == pidtc_pkg::S_WRITE && result.valid && !result.ready |=>
      state == pidtc_pkg::S_WRITE && result.valid)
    else $error("result register overwritten while full");

endmodule

`default_nettype wire
